[rtl/vn_pkg.sv]
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths and item types for the vector normaliser.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int IN_WIDTH   = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_WIDTH  = FRAC_BITS + 2;
  localparam int SQ_WIDTH   = 2 * IN_WIDTH;
  localparam int SUM_WIDTH  = 2 * IN_WIDTH + 2;
  localparam int ACC_WIDTH  = 2 * FRAC_BITS + SUM_WIDTH + 2;
  localparam int Q_WIDTH    = FRAC_BITS + 1;
  localparam int LANE_DEPTH = FRAC_BITS + 1;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] x_in;
    logic signed [IN_WIDTH-1:0] y_in;
    logic signed [IN_WIDTH-1:0] z_in;
  } vec_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] x_unit;
    logic signed [OUT_WIDTH-1:0] y_unit;
    logic signed [OUT_WIDTH-1:0] z_unit;
    logic                        zero_error;
  } vec_out_t;

endpackage

[rtl/vn_root_lane.sv]
// ----------------------------------------------------------------------------
// vn_root_lane
// Pipelined restoring search for one output magnitude, one bit per stage.
// ----------------------------------------------------------------------------
module vn_root_lane (
  input  logic                         clk,
  input  logic [vn_pkg::SQ_WIDTH-1:0]  sq,
  input  logic [vn_pkg::SUM_WIDTH-1:0] sum,
  input  logic                         neg,
  output logic [vn_pkg::Q_WIDTH-1:0]   q,
  output logic                         q_neg
);
  import vn_pkg::*;

  // Each stage holds q, q*q*S, q*S, the limit and S, so that trying a new bit
  // needs only shifts and adds.
  logic [Q_WIDTH-1:0]   st_q    [0:LANE_DEPTH];
  logic [ACC_WIDTH-1:0] st_p    [0:LANE_DEPTH];
  logic [ACC_WIDTH-1:0] st_qs   [0:LANE_DEPTH];
  logic [ACC_WIDTH-1:0] st_lim  [0:LANE_DEPTH];
  logic [SUM_WIDTH-1:0] st_sum  [0:LANE_DEPTH];
  logic                 st_neg  [0:LANE_DEPTH];

  assign st_q[0]   = '0;
  assign st_p[0]   = '0;
  assign st_qs[0]  = '0;
  assign st_lim[0] = ACC_WIDTH'(sq) << (2 * FRAC_BITS);
  assign st_sum[0] = sum;
  assign st_neg[0] = neg;

  genvar k;
  generate
    for (k = 0; k < LANE_DEPTH; k++) begin : g_stage
      localparam int B = FRAC_BITS - k;
      logic [ACC_WIDTH-1:0] s_wide;
      logic [ACC_WIDTH-1:0] cand;
      logic                 take;

      assign s_wide = ACC_WIDTH'(st_sum[k]);
      // (q + 2^B)^2 * S = q^2*S + 2^(B+1)*q*S + 2^(2B)*S
      assign cand = st_p[k] + (st_qs[k] << (B + 1)) + (s_wide << (2 * B));
      assign take = (cand <= st_lim[k]);

      always_ff @(posedge clk) begin
        st_q[k+1]   <= take ? (st_q[k] | (Q_WIDTH'(1) << B)) : st_q[k];
        st_p[k+1]   <= take ? cand : st_p[k];
        st_qs[k+1]  <= take ? (st_qs[k] + (s_wide << B)) : st_qs[k];
        st_lim[k+1] <= st_lim[k];
        st_sum[k+1] <= st_sum[k];
        st_neg[k+1] <= st_neg[k];
      end
    end
  endgenerate

  assign q     = st_q[LANE_DEPTH];
  assign q_neg = st_neg[LANE_DEPTH];

endmodule

[rtl/vector3_normalize.sv]
// ----------------------------------------------------------------------------
// vector3_normalize
// Exact fixed-point normalisation of a signed 3-vector to signed Q1.14.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                    Handshake
//   input     start, busy, operands    taken when start is high and busy is low
//   result    done, result             done high for one cycle per item
//
// The block is a fixed pipeline: an item may enter on every cycle; its
// result passes the capture, squaring and summing registers, then the
// one-bit-per-stage magnitude search in each lane and the output register.
// Busy is held low; the receiver cannot stall, so nothing ever waits.
// Reset clears the valid bits only; data registers are left as they are.
//
module vector3_normalize (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vn_pkg::vec_in_t  operands,
  output logic             done,
  output vn_pkg::vec_out_t result
);
  import vn_pkg::*;

  // Stage one: capture the item.
  logic    s1_valid;
  vec_in_t s1_item;

  // Stage two: magnitudes squared and signs.
  logic                s2_valid;
  logic [SQ_WIDTH-1:0] s2_sq  [0:2];
  logic                s2_neg [0:2];

  // Stage three: sum of squares, fed to the three lanes.
  logic                 s3_valid;
  logic [SQ_WIDTH-1:0]  s3_sq  [0:2];
  logic                 s3_neg [0:2];
  logic [SUM_WIDTH-1:0] s3_sum;

  logic [IN_WIDTH-1:0] mag   [0:2];
  logic [IN_WIDTH-1:0] raw   [0:2];

  // Valid bits and the zero flag travel alongside the lanes.
  logic lane_valid [0:LANE_DEPTH-1];
  logic lane_zero  [0:LANE_DEPTH-1];

  logic [Q_WIDTH-1:0] lane_q   [0:2];
  logic               lane_neg [0:2];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= operands;
  end

  assign raw[0] = s1_item.x_in;
  assign raw[1] = s1_item.y_in;
  assign raw[2] = s1_item.z_in;

  // The most negative input has a magnitude that still fits unsigned.
  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_comp
      assign mag[i] = raw[i][IN_WIDTH-1] ? (~raw[i] + IN_WIDTH'(1)) : raw[i];

      always_ff @(posedge clk) begin
        s2_sq[i]  <= SQ_WIDTH'(mag[i]) * SQ_WIDTH'(mag[i]);
        s2_neg[i] <= raw[i][IN_WIDTH-1];
        s3_sq[i]  <= s2_sq[i];
        s3_neg[i] <= s2_neg[i];
      end

      vn_root_lane u_lane (
        .clk   (clk),
        .sq    (s3_sq[i]),
        .sum   (s3_sum),
        .neg   (s3_neg[i]),
        .q     (lane_q[i]),
        .q_neg (lane_neg[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    s3_sum <= SUM_WIDTH'(s2_sq[0]) + SUM_WIDTH'(s2_sq[1]) + SUM_WIDTH'(s2_sq[2]);
  end

  genvar k;
  generate
    for (k = 0; k < LANE_DEPTH; k++) begin : g_delay
      always_ff @(posedge clk) begin
        if (rst) begin
          lane_valid[k] <= 1'b0;
        end else begin
          lane_valid[k] <= (k == 0) ? s3_valid : lane_valid[(k == 0) ? 0 : k - 1];
        end
      end

      always_ff @(posedge clk) begin
        lane_zero[k] <= (k == 0) ? (s3_sum == '0) : lane_zero[(k == 0) ? 0 : k - 1];
      end
    end
  endgenerate

  // Final stage: apply the signs, and force zeros for an all-zero vector.
  function automatic logic [OUT_WIDTH-1:0] signed_unit(
    input logic [Q_WIDTH-1:0] q,
    input logic               neg,
    input logic               zero
  );
    logic [OUT_WIDTH-1:0] wide;
    wide = OUT_WIDTH'(q);
    if (zero) begin
      return '0;
    end
    return neg ? (~wide + OUT_WIDTH'(1)) : wide;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_valid[LANE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    result.x_unit     <= signed_unit(lane_q[0], lane_neg[0], lane_zero[LANE_DEPTH-1]);
    result.y_unit     <= signed_unit(lane_q[1], lane_neg[1], lane_zero[LANE_DEPTH-1]);
    result.z_unit     <= signed_unit(lane_q[2], lane_neg[2], lane_zero[LANE_DEPTH-1]);
    result.zero_error <= lane_zero[LANE_DEPTH-1];
  end

endmodule

[tb/sv/vector3_normalize_test.sv]
// ----------------------------------------------------------------------------
// vector3_normalize_test
// Self-checking bench for the vector normaliser: a directed table of vectors
// (extremes, zero vector, zero components, the most negative input) followed
// by random vectors sent in bursts, each result compared with an exact
// integer predictor of the truncated unit vector.
// ----------------------------------------------------------------------------
module vector3_normalize_test;

  timeunit 1ns;
  timeprecision 1ps;

  import vn_pkg::*;

  localparam int PIPE_CYCLES  = FRAC_BITS + 5;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 450;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  vec_in_t  operands;
  logic     done;
  vec_out_t result;

  // Expected results, oldest first.
  vec_out_t unit_queue[$];
  bit       failed;
  int       idle_cycles;

  // One row of the directed table. Where has_expect is set, the expected
  // result is the typed-in one and must also agree with the predictor.
  typedef struct {
    vec_in_t  vec;
    bit       has_expect;
    vec_out_t unit;
  } vec_row_t;

  vector3_normalize i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Largest q in 0..2^FRAC_BITS with q*q*sum <= mag*mag*2^(2*FRAC_BITS),
  // found one bit at a time, exactly as a truncated |c|/sqrt(sum).
  function automatic logic [Q_WIDTH-1:0] unit_magnitude(logic [IN_WIDTH:0] mag,
                                                        logic [127:0] sum);
    logic [127:0]       limit;
    logic [127:0]       trial;
    logic [Q_WIDTH-1:0] q;
    q = '0;
    limit = (128'(mag) * 128'(mag)) << (2 * FRAC_BITS);
    for (int b = FRAC_BITS; b >= 0; b--) begin
      trial = 128'(q | (Q_WIDTH'(1) << b));
      if (trial * trial * sum <= limit) begin
        q = q | (Q_WIDTH'(1) << b);
      end
    end
    return q;
  endfunction

  function automatic vec_out_t normalise(vec_in_t v);
    logic signed [IN_WIDTH-1:0] comp[3];
    logic        [IN_WIDTH:0]   mag[3];
    logic        [127:0]        sum;
    logic        [Q_WIDTH-1:0]  q;
    logic        [OUT_WIDTH-1:0] unit[3];
    vec_out_t                   r;
    comp[0] = v.x_in;
    comp[1] = v.y_in;
    comp[2] = v.z_in;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      // The most negative input keeps its full magnitude in the extra bit.
      mag[i] = comp[i][IN_WIDTH-1] ? -{comp[i][IN_WIDTH-1], comp[i]}
                                   : {1'b0, comp[i]};
      sum += 128'(mag[i]) * 128'(mag[i]);
    end
    r = '0;
    if (sum == 0) begin
      r.zero_error = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q = unit_magnitude(mag[i], sum);
      unit[i] = comp[i][IN_WIDTH-1] ? -OUT_WIDTH'(q) : OUT_WIDTH'(q);
    end
    r.x_unit = unit[0];
    r.y_unit = unit[1];
    r.z_unit = unit[2];
    return r;
  endfunction

  function automatic vec_in_t make_vec(int x, int y, int z);
    vec_in_t v;
    v.x_in = x[IN_WIDTH-1:0];
    v.y_in = y[IN_WIDTH-1:0];
    v.z_in = z[IN_WIDTH-1:0];
    return v;
  endfunction

  function automatic vec_out_t make_unit(int x, int y, int z, bit err);
    vec_out_t u;
    u.x_unit = x[OUT_WIDTH-1:0];
    u.y_unit = y[OUT_WIDTH-1:0];
    u.z_unit = z[OUT_WIDTH-1:0];
    u.zero_error = err;
    return u;
  endfunction

  // Random component: full range half of the time, else zero, an extreme or a small
  // value so that near-axis and tiny vectors turn up often.
  function automatic logic [IN_WIDTH-1:0] random_component();
    case ($urandom_range(7))
      0: return '0;
      1: return {1'b1, {(IN_WIDTH-1){1'b0}}};
      2: return {1'b0, {(IN_WIDTH-1){1'b1}}};
      3: return IN_WIDTH'($urandom_range(8)) - IN_WIDTH'(4);
      default: return IN_WIDTH'($urandom);
    endcase
  endfunction

  // Offers one vector at the falling edge and holds it until it is taken.
  task automatic send_vector(vec_in_t v);
    start <= 1'b1;
    operands <= v;
    do begin
      @(posedge clk);
    end while (busy);
    unit_queue.push_back(normalise(v));
  endtask

  // Sender gap: lowers start for a random number of cycles.
  task automatic sender_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Results are checked at the rising edge that ends their cycle.
  always @(posedge clk) begin
    vec_out_t want;
    if (!rst && done) begin
      if (unit_queue.size() == 0) begin
        $error("result with no item outstanding: %p", result);
        failed = 1'b1;
      end else begin
        want = unit_queue.pop_front();
        if (result.x_unit !== want.x_unit) begin
          $error("x_unit: expected %0d, actual %0d", want.x_unit, result.x_unit);
          failed = 1'b1;
        end
        if (result.y_unit !== want.y_unit) begin
          $error("y_unit: expected %0d, actual %0d", want.y_unit, result.y_unit);
          failed = 1'b1;
        end
        if (result.z_unit !== want.z_unit) begin
          $error("z_unit: expected %0d, actual %0d", want.z_unit, result.z_unit);
          failed = 1'b1;
        end
        if (result.zero_error !== want.zero_error) begin
          $error("zero_error: expected %0b, actual %0b",
                 want.zero_error, result.zero_error);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** vector3_normalize: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    vec_row_t directed[$];
    vec_out_t typed;
    int       burst;
    int       sent;
    int       tail;

    failed = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    operands = '0;

    // Rows with a typed-in result are those readable at a glance: the zero
    // vector, axis vectors, the extremes of a single component and (3, 4, 0).
    directed.push_back('{make_vec(0, 0, 0), 1, make_unit(0, 0, 0, 1)});
    directed.push_back('{make_vec(1, 0, 0), 1, make_unit(16384, 0, 0, 0)});
    directed.push_back('{make_vec(0, -1, 0), 1, make_unit(0, -16384, 0, 0)});
    directed.push_back('{make_vec(0, 0, 32767), 1, make_unit(0, 0, 16384, 0)});
    directed.push_back('{make_vec(-32768, 0, 0), 1, make_unit(-16384, 0, 0, 0)});
    directed.push_back('{make_vec(0, -32768, 0), 1, make_unit(0, -16384, 0, 0)});
    directed.push_back('{make_vec(0, 0, -32768), 1, make_unit(0, 0, -16384, 0)});
    directed.push_back('{make_vec(3, 4, 0), 1, make_unit(9830, 13107, 0, 0)});
    directed.push_back('{make_vec(0, 0, 0), 1, make_unit(0, 0, 0, 1)});
    directed.push_back('{make_vec(32767, 32767, 32767), 0, '0});
    directed.push_back('{make_vec(-32768, -32768, -32768), 0, '0});
    directed.push_back('{make_vec(-32768, 32767, -32768), 0, '0});
    directed.push_back('{make_vec(1, 1, 1), 0, '0});
    directed.push_back('{make_vec(-1, 1, -1), 0, '0});
    directed.push_back('{make_vec(32767, 1, 0), 0, '0});
    directed.push_back('{make_vec(-32768, 0, 1), 0, '0});
    directed.push_back('{make_vec(1, 2, 2), 0, '0});
    directed.push_back('{make_vec(21845, -10922, 5461), 0, '0});
    directed.push_back('{make_vec(-21846, 10921, -5462), 0, '0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, back to back.
    foreach (directed[i]) begin
      if (directed[i].has_expect) begin
        typed = normalise(directed[i].vec);
        if (typed !== directed[i].unit) begin
          $error("table row %0d: typed result %p, predicted %p",
                 i, directed[i].unit, typed);
          failed = 1'b1;
        end
      end
      send_vector(directed[i].vec);
      @(negedge clk);
    end

    // Random part in bursts with no gaps inside; some bursts follow on with no gap at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_vector(vec_in_t'({random_component(), random_component(),
                               random_component()}));
        sent++;
        @(negedge clk);
      end
      sender_gap($urandom_range(3) == 0 ? 0 : $urandom_range(6));
    end
    start <= 1'b0;

    // Drain: wait for every result, then idle on so that a stray extra result is caught.
    tail = 0;
    while (unit_queue.size() != 0 && tail < 50 * PIPE_CYCLES) begin
      @(posedge clk);
      tail++;
    end
    repeat (2 * PIPE_CYCLES) @(posedge clk);

    if (!failed && unit_queue.size() == 0) begin
      $display("** vector3_normalize: PASSED **");
    end else begin
      if (unit_queue.size() != 0) begin
        $error("%0d results never arrived", unit_queue.size());
      end
      $display("** vector3_normalize: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/vn_pkg.sv
rtl/vn_root_lane.sv
rtl/vector3_normalize.sv
tb/sv/vector3_normalize_test.sv
